>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/mhts_pkg.sv
// ----------------------------------------------------------------------------
// mhts_pkg
// Types and constants of the min-heap timer scheduler.
// ----------------------------------------------------------------------------
package mhts_pkg;

    localparam int MAX_TIMERS = 32;
    localparam int ID_W       = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int CHILD_W    = ID_W + 2;
    localparam int NOW_W      = 48;
    localparam int IVAL_W     = 32;
    localparam int DL_W       = 64;
    localparam int MS_W       = 10;
    localparam int PROD_W     = IVAL_W + MS_W;
    localparam logic [MS_W-1:0] US_PER_MS = MS_W'(1000);

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_TICK = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_ADD_FULL  = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_DEL_UNKN  = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_TICK_DONE = 3'd5
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_SUM, S_UP_CHK, S_UP_CMP, S_PLACE,
        S_DN_CHK, S_DN_L, S_DN_R, S_DN_CMP,
        S_ER_START, S_ER_LAST, S_ER_PAR, S_DEL_POS, S_TICK_CHK, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CONT_EMIT,
        CONT_POP,
        CONT_REPUSH
    } t_cont;

    typedef struct packed {
        logic [1:0]        action;
        logic [NOW_W-1:0]  now_us;
        logic [IVAL_W-1:0] interval_ms;
        logic              repeat_req;
        logic [4:0]        timer_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [4:0]  result_id;
        logic [5:0]  active_count;
        logic [63:0] nearest_deadline;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic [ID_W-1:0] own;
    } t_heap_ent;

    typedef struct packed {
        logic              rep;
        logic [IVAL_W-1:0] ival;
    } t_ival_ent;

endpackage

>>> rtl/core/mhts_ram.sv
// ----------------------------------------------------------------------------
// mhts_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mhts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mhts_core.sv
// ----------------------------------------------------------------------------
// mhts_core
// Heap sequencer: sift up/down through the single heap RAM read port with a shared comparator.
// ----------------------------------------------------------------------------
module mhts_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mhts_pkg::t_in  i_in,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output mhts_pkg::t_out o_res
);

    localparam int ID_W    = mhts_pkg::ID_W;
    localparam int CNT_W   = mhts_pkg::CNT_W;
    localparam int CHILD_W = mhts_pkg::CHILD_W;
    localparam int DL_W    = mhts_pkg::DL_W;

    mhts_pkg::t_state r_state, n_state;
    mhts_pkg::t_cont  r_cont, n_cont;
    mhts_pkg::t_kind  r_kind, n_kind;

    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [mhts_pkg::MAX_TIMERS-1:0] r_in_use, n_in_use;
    logic [DL_W-1:0]                r_top;
    logic [ID_W-1:0]                r_top_own;
    logic [ID_W-1:0]                r_hole, n_hole;
    logic [ID_W-1:0]                r_par, n_par;
    logic [ID_W-1:0]                r_selidx, n_selidx;
    logic [DL_W-1:0]                r_dl, n_dl;
    logic [ID_W-1:0]                r_own, n_own;
    logic [ID_W-1:0]                r_id, n_id;
    logic                           r_last, n_last;
    logic [mhts_pkg::NOW_W-1:0]     r_now, n_now;
    logic [mhts_pkg::IVAL_W-1:0]    r_ival, n_ival;
    logic [mhts_pkg::PROD_W-1:0]    r_prod, n_prod;
    mhts_pkg::t_heap_ent            r_left, n_left;
    mhts_pkg::t_heap_ent            r_sel, n_sel;

    logic                  h_we, h_re;
    logic [ID_W-1:0]       h_waddr, h_raddr;
    mhts_pkg::t_heap_ent   h_wdata, h_rdata;
    logic                  p_we, p_re;
    logic [ID_W-1:0]       p_waddr, p_raddr, p_wdata, p_rdata;
    logic                  v_we, v_re;
    logic [ID_W-1:0]       v_waddr, v_raddr;
    mhts_pkg::t_ival_ent   v_wdata, v_rdata;

    logic                        accept;
    logic                        free_found;
    logic [ID_W-1:0]             free_id;
    logic [CHILD_W-1:0]          child;
    logic [CHILD_W-1:0]          child_m1;
    logic [ID_W-1:0]             parent;
    logic [mhts_pkg::IVAL_W-1:0] ms1;
    logic [DL_W-1:0]             cmp_a, cmp_b;
    logic                        cmp_gt;
    logic                        pop;

    mhts_ram #(.WIDTH($bits(mhts_pkg::t_heap_ent)), .DEPTH(mhts_pkg::MAX_TIMERS)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_re(h_re), .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    mhts_ram #(.WIDTH(ID_W), .DEPTH(mhts_pkg::MAX_TIMERS)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_re(p_re), .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    mhts_ram #(.WIDTH($bits(mhts_pkg::t_ival_ent)), .DEPTH(mhts_pkg::MAX_TIMERS)) u_ival (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_re(v_re), .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    assign accept     = i_in_valid && (r_state == mhts_pkg::S_IDLE);
    assign o_in_ready = (r_state == mhts_pkg::S_IDLE);
    assign child      = {1'b0, r_hole, 1'b0} + CHILD_W'(2);
    assign child_m1   = child - CHILD_W'(1);
    assign parent     = (r_hole - ID_W'(1)) >> 1;
    assign ms1        = (i_in.interval_ms == '0) ? mhts_pkg::IVAL_W'(1) : i_in.interval_ms;
    assign pop        = (r_cnt != '0) && !cmp_gt;

    always_comb begin
        free_found = 1'b0;
        free_id    = '0;
        for (int k = mhts_pkg::MAX_TIMERS - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                free_found = 1'b1;
                free_id    = ID_W'(k);
            end
        end
    end

    // shared comparator
    always_comb begin
        case (r_state)
            mhts_pkg::S_TICK_CHK: begin
                cmp_a = r_top;
                cmp_b = DL_W'(r_now);
            end
            mhts_pkg::S_UP_CMP, mhts_pkg::S_ER_PAR: begin
                cmp_a = h_rdata.dl;
                cmp_b = r_dl;
            end
            mhts_pkg::S_DN_R: begin
                cmp_a = h_rdata.dl;
                cmp_b = r_left.dl;
            end
            mhts_pkg::S_DN_CMP: begin
                cmp_a = r_dl;
                cmp_b = r_sel.dl;
            end
            default: begin
                cmp_a = r_dl;
                cmp_b = r_dl;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mhts_pkg::S_IDLE: begin
                if (accept) begin
                    case (mhts_pkg::t_action'(i_in.action))
                        mhts_pkg::ACT_ADD:  n_state = free_found ? mhts_pkg::S_MUL
                                                                 : mhts_pkg::S_EMIT;
                        mhts_pkg::ACT_DEL:  n_state = r_in_use[i_in.timer_id]
                                                    ? mhts_pkg::S_DEL_POS : mhts_pkg::S_EMIT;
                        mhts_pkg::ACT_TICK: n_state = mhts_pkg::S_TICK_CHK;
                        default:            n_state = mhts_pkg::S_IDLE;
                    endcase
                end
            end
            mhts_pkg::S_MUL:    n_state = mhts_pkg::S_SUM;
            mhts_pkg::S_SUM:    n_state = mhts_pkg::S_UP_CHK;
            mhts_pkg::S_UP_CHK: n_state = (r_hole == '0) ? mhts_pkg::S_PLACE
                                                         : mhts_pkg::S_UP_CMP;
            mhts_pkg::S_UP_CMP: n_state = cmp_gt ? mhts_pkg::S_UP_CHK : mhts_pkg::S_PLACE;
            mhts_pkg::S_PLACE: begin
                if (r_cont == mhts_pkg::CONT_POP && v_rdata.rep) begin
                    n_state = mhts_pkg::S_MUL;
                end else begin
                    n_state = mhts_pkg::S_EMIT;
                end
            end
            mhts_pkg::S_DN_CHK: n_state = (child > CHILD_W'(r_cnt)) ? mhts_pkg::S_PLACE
                                                                   : mhts_pkg::S_DN_L;
            mhts_pkg::S_DN_L:   n_state = (child == CHILD_W'(r_cnt)) ? mhts_pkg::S_DN_CMP
                                                                    : mhts_pkg::S_DN_R;
            mhts_pkg::S_DN_R:   n_state = mhts_pkg::S_DN_CMP;
            mhts_pkg::S_DN_CMP: n_state = cmp_gt ? mhts_pkg::S_DN_CHK : mhts_pkg::S_PLACE;
            mhts_pkg::S_ER_START: n_state = mhts_pkg::S_ER_LAST;
            mhts_pkg::S_ER_LAST: n_state = (r_hole == '0) ? mhts_pkg::S_DN_CHK
                                                          : mhts_pkg::S_ER_PAR;
            mhts_pkg::S_ER_PAR: n_state = cmp_gt ? mhts_pkg::S_UP_CHK : mhts_pkg::S_DN_CHK;
            mhts_pkg::S_DEL_POS: n_state = mhts_pkg::S_ER_START;
            mhts_pkg::S_TICK_CHK: n_state = pop ? mhts_pkg::S_ER_START : mhts_pkg::S_EMIT;
            mhts_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    n_state = r_last ? mhts_pkg::S_IDLE : mhts_pkg::S_TICK_CHK;
                end
            end
            default: n_state = mhts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cont   = r_cont;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        n_in_use = r_in_use;
        n_hole   = r_hole;
        n_par    = r_par;
        n_selidx = r_selidx;
        n_dl     = r_dl;
        n_own    = r_own;
        n_id     = r_id;
        n_last   = r_last;
        n_now    = r_now;
        n_ival   = r_ival;
        n_prod   = r_prod;
        n_left   = r_left;
        n_sel    = r_sel;
        h_we     = 1'b0;
        h_waddr  = r_hole;
        h_wdata  = '{dl: r_dl, own: r_own};
        h_re     = 1'b0;
        h_raddr  = parent;
        p_we     = 1'b0;
        p_waddr  = r_own;
        p_wdata  = r_hole;
        p_re     = 1'b0;
        p_raddr  = i_in.timer_id;
        v_we     = 1'b0;
        v_waddr  = free_id;
        v_wdata  = '{rep: i_in.repeat_req, ival: ms1};
        v_re     = 1'b0;
        v_raddr  = r_top_own;
        case (r_state)
            mhts_pkg::S_IDLE: begin
                if (accept) begin
                    n_now  = i_in.now_us;
                    n_last = 1'b1;
                    n_cont = mhts_pkg::CONT_EMIT;
                    case (mhts_pkg::t_action'(i_in.action))
                        mhts_pkg::ACT_ADD: begin
                            if (free_found) begin
                                n_in_use[free_id] = 1'b1;
                                v_we   = 1'b1;
                                n_ival = ms1;
                                n_id   = free_id;
                                n_kind = mhts_pkg::KIND_ADDED;
                            end else begin
                                n_id   = '0;
                                n_kind = mhts_pkg::KIND_ADD_FULL;
                            end
                        end
                        mhts_pkg::ACT_DEL: begin
                            n_id = i_in.timer_id;
                            if (r_in_use[i_in.timer_id]) begin
                                n_in_use[i_in.timer_id] = 1'b0;
                                p_re   = 1'b1;
                                n_kind = mhts_pkg::KIND_DELETED;
                            end else begin
                                n_kind = mhts_pkg::KIND_DEL_UNKN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mhts_pkg::S_MUL: n_prod = r_ival * mhts_pkg::US_PER_MS;
            mhts_pkg::S_SUM: begin
                n_dl   = DL_W'(r_now) + DL_W'(r_prod);
                n_own  = r_id;
                n_hole = r_cnt[ID_W-1:0];
                n_cnt  = r_cnt + CNT_W'(1);
            end
            mhts_pkg::S_UP_CHK: begin
                if (r_hole != '0) begin
                    h_re  = 1'b1;
                    n_par = parent;
                end
            end
            mhts_pkg::S_UP_CMP: begin
                if (cmp_gt) begin
                    h_we    = 1'b1;
                    h_wdata = h_rdata;
                    p_we    = 1'b1;
                    p_waddr = h_rdata.own;
                    n_hole  = r_par;
                end
            end
            mhts_pkg::S_PLACE: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (r_cont == mhts_pkg::CONT_POP) begin
                    if (v_rdata.rep) begin
                        n_ival = v_rdata.ival;
                        n_cont = mhts_pkg::CONT_REPUSH;
                    end else begin
                        n_in_use[r_id] = 1'b0;
                    end
                end
            end
            mhts_pkg::S_DN_CHK: begin
                if (child <= CHILD_W'(r_cnt)) begin
                    h_re    = 1'b1;
                    h_raddr = child_m1[ID_W-1:0];
                end
            end
            mhts_pkg::S_DN_L: begin
                n_left = h_rdata;
                if (child == CHILD_W'(r_cnt)) begin
                    n_sel    = h_rdata;
                    n_selidx = child_m1[ID_W-1:0];
                end else begin
                    h_re    = 1'b1;
                    h_raddr = child[ID_W-1:0];
                end
            end
            mhts_pkg::S_DN_R: begin
                if (cmp_gt) begin
                    n_sel    = r_left;
                    n_selidx = child_m1[ID_W-1:0];
                end else begin
                    n_sel    = h_rdata;
                    n_selidx = child[ID_W-1:0];
                end
            end
            mhts_pkg::S_DN_CMP: begin
                if (cmp_gt) begin
                    h_we    = 1'b1;
                    h_wdata = r_sel;
                    p_we    = 1'b1;
                    p_waddr = r_sel.own;
                    n_hole  = r_selidx;
                end
            end
            mhts_pkg::S_ER_START: begin
                n_cnt   = r_cnt - CNT_W'(1);
                h_re    = 1'b1;
                h_raddr = ID_W'(r_cnt - CNT_W'(1));
            end
            mhts_pkg::S_ER_LAST: begin
                n_dl  = h_rdata.dl;
                n_own = h_rdata.own;
                if (r_hole != '0) begin
                    h_re = 1'b1;
                end
            end
            mhts_pkg::S_DEL_POS: n_hole = p_rdata;
            mhts_pkg::S_TICK_CHK: begin
                if (pop) begin
                    n_id   = r_top_own;
                    n_hole = '0;
                    v_re   = 1'b1;
                    n_cont = mhts_pkg::CONT_POP;
                    n_kind = mhts_pkg::KIND_EXPIRED;
                    n_last = 1'b0;
                end else begin
                    n_id   = '0;
                    n_kind = mhts_pkg::KIND_TICK_DONE;
                    n_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mhts_pkg::S_IDLE;
            r_cnt    <= '0;
            r_in_use <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_in_use <= n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cont   <= n_cont;
        r_kind   <= n_kind;
        r_hole   <= n_hole;
        r_par    <= n_par;
        r_selidx <= n_selidx;
        r_dl     <= n_dl;
        r_own    <= n_own;
        r_id     <= n_id;
        r_last   <= n_last;
        r_now    <= n_now;
        r_ival   <= n_ival;
        r_prod   <= n_prod;
        r_left   <= n_left;
        r_sel    <= n_sel;
        if (h_we && h_waddr == '0) begin
            r_top     <= h_wdata.dl;
            r_top_own <= h_wdata.own;
        end
    end

    assign o_res_valid                 = (r_state == mhts_pkg::S_EMIT);
    assign o_res.event_kind            = r_kind;
    assign o_res.result_id             = r_id;
    assign o_res.active_count          = r_cnt;
    assign o_res.nearest_deadline      = (r_cnt != '0) ? r_top : '0;
    assign o_res.last                  = r_last;

endmodule

>>> rtl/core/min_heap_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// min_heap_timer_scheduler_top
// Timer scheduler over a binary min-heap of deadlines, with output register.
//
//   channel | valid   | ready   | payload
//   in      | i_valid | o_ready | i_data (mhts_pkg::t_in)
//   out     | o_valid | i_ready | o_data (mhts_pkg::t_out)
//
// Add climbs the new deadline toward the root. Delete and expiry move the
// last entry into the hole and sift it up or down; a re-armed expiry adds
// a push. Each step goes through the single heap RAM read port.
// Reset clears the count and id map; no clearing pass.
// Input is taken only while idle; a stalled output beat holds the sequencer.
// ----------------------------------------------------------------------------
module min_heap_timer_scheduler_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mhts_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mhts_pkg::t_out o_data
);

    logic           res_valid;
    logic           res_ready;
    mhts_pkg::t_out res;
    logic           r_o_valid;
    mhts_pkg::t_out r_o_data;

    mhts_core u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .o_in_ready(o_ready),
        .i_in(i_data),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res(res)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_o_data <= res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

>>> rtl/core/mhts_checker.sv
// ----------------------------------------------------------------------------
// mhts_checker
// Port-level checks on the scheduler's result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhts_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input mhts_pkg::t_out o_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, o_valid, o_data.active_count <= 6'd32)
    `ASSERT_NOW(a_empty_dl, i_clk, i_rst_n, o_valid && o_data.active_count == '0, o_data.nearest_deadline == '0)
    `ASSERT_NOW(a_single_last, i_clk, i_rst_n, o_valid && o_data.event_kind != mhts_pkg::KIND_EXPIRED, o_data.last)
    `ASSERT_NOW(a_done_id, i_clk, i_rst_n, o_valid && o_data.event_kind == mhts_pkg::KIND_TICK_DONE, o_data.result_id == '0)

endmodule

bind min_heap_timer_scheduler_top mhts_checker u_mhts_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data(o_data)
);

>>> test/min_heap_timer_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_timer_scheduler_top_tb
// Drives add, delete and tick commands into the timer scheduler and checks
// every output beat against a behavioural heap model kept in the bench.
// ----------------------------------------------------------------------------
module min_heap_timer_scheduler_top_tb;
    import mhts_pkg::*;

    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    min_heap_timer_scheduler_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scheduler model
    logic [63:0] hp_dl [MAX_TIMERS];
    logic [4:0]  hp_own [MAX_TIMERS];
    int          id_pos [MAX_TIMERS];
    logic [31:0] id_ival [MAX_TIMERS];
    logic        id_rep [MAX_TIMERS];
    logic        id_used [MAX_TIMERS];
    int          hp_cnt = 0;

    t_in  cmd_q [$];
    t_out beat_q [$];
    int   errors = 0;
    int   cycles = 0;
    bit   stim_done = 0;
    bit   hold_rx = 0;
    int   rx_gap = 0;
    int   tx_gap = 0;
    logic [47:0] clock_us = 48'd0;

    function automatic logic [63:0] due_time(logic [47:0] now, logic [31:0] ms);
        logic [63:0] d;
        logic [63:0] s;
        d = 64'(ms == 0 ? 32'd1 : ms) * 64'd1000;
        s = 64'(now) + d;
        return (s < 64'(now)) ? '1 : s;
    endfunction

    function automatic void put_slot(int slot, logic [63:0] dl, logic [4:0] own);
        hp_dl[slot] = dl;
        hp_own[slot] = own;
        id_pos[own] = slot;
    endfunction

    function automatic void climb(int hole, logic [63:0] dl, logic [4:0] own);
        int par;
        while (hole > 0) begin
            par = (hole - 1) / 2;
            if (!(hp_dl[par] > dl)) break;
            put_slot(hole, hp_dl[par], hp_own[par]);
            hole = par;
        end
        put_slot(hole, dl, own);
    endfunction

    function automatic void descend(int hole, logic [63:0] dl, logic [4:0] own);
        int ch;
        ch = 2 * (hole + 1);
        while (ch <= hp_cnt) begin
            if (ch == hp_cnt || hp_dl[ch] > hp_dl[ch-1]) ch--;
            if (!(dl > hp_dl[ch])) break;
            put_slot(hole, hp_dl[ch], hp_own[ch]);
            hole = ch;
            ch = 2 * (hole + 1);
        end
        climb(hole, dl, own);
    endfunction

    function automatic void remove_at(int pos);
        hp_cnt--;
        if (pos > 0 && hp_dl[(pos-1)/2] > hp_dl[hp_cnt])
            climb(pos, hp_dl[hp_cnt], hp_own[hp_cnt]);
        else
            descend(pos, hp_dl[hp_cnt], hp_own[hp_cnt]);
    endfunction

    function automatic void note(t_kind k, logic [4:0] id, logic lst);
        t_out o;
        o.event_kind = k;
        o.result_id = id;
        o.active_count = 6'(hp_cnt);
        o.nearest_deadline = hp_cnt != 0 ? hp_dl[0] : 64'd0;
        o.last = lst;
        beat_q.push_back(o);
    endfunction

    function automatic void predict_events(t_in c);
        int id;
        logic [4:0] own;
        case (c.action)
            ACT_ADD: begin
                id = 0;
                while (id < MAX_TIMERS && id_used[id]) id++;
                if (id >= MAX_TIMERS || hp_cnt >= MAX_TIMERS) begin
                    note(KIND_ADD_FULL, 5'd0, 1'b1);
                end else begin
                    id_used[id] = 1'b1;
                    id_ival[id] = c.interval_ms == 0 ? 32'd1 : c.interval_ms;
                    id_rep[id] = c.repeat_req;
                    hp_cnt++;
                    climb(hp_cnt - 1, due_time(c.now_us, c.interval_ms), 5'(id));
                    note(KIND_ADDED, 5'(id), 1'b1);
                end
            end
            ACT_DEL: begin
                if (!id_used[c.timer_id]) begin
                    note(KIND_DEL_UNKN, c.timer_id, 1'b1);
                end else begin
                    id_used[c.timer_id] = 1'b0;
                    remove_at(id_pos[c.timer_id]);
                    note(KIND_DELETED, c.timer_id, 1'b1);
                end
            end
            ACT_TICK: begin
                while (hp_cnt > 0 && !(hp_dl[0] > 64'(c.now_us))) begin
                    own = hp_own[0];
                    remove_at(0);
                    if (id_rep[own]) begin
                        hp_cnt++;
                        climb(hp_cnt - 1, due_time(c.now_us, id_ival[own]), own);
                    end else begin
                        id_used[own] = 1'b0;
                    end
                    note(KIND_EXPIRED, own, 1'b0);
                end
                note(KIND_TICK_DONE, 5'd0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_events(i_data);
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    i_data <= cmd_q.pop_front();
                    i_valid <= 1'b1;
                    tx_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                        : $urandom_range(10, 40);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (beat_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_data.result_id), 64'd0);
                end else begin
                    if (o_data.event_kind != beat_q[0].event_kind)
                        report_mismatch("event_kind", 64'(o_data.event_kind),
                                        64'(beat_q[0].event_kind));
                    if (o_data.result_id != beat_q[0].result_id)
                        report_mismatch("result_id", 64'(o_data.result_id),
                                        64'(beat_q[0].result_id));
                    if (o_data.active_count != beat_q[0].active_count)
                        report_mismatch("active_count", 64'(o_data.active_count),
                                        64'(beat_q[0].active_count));
                    if (o_data.nearest_deadline != beat_q[0].nearest_deadline)
                        report_mismatch("nearest_deadline", o_data.nearest_deadline,
                                        beat_q[0].nearest_deadline);
                    if (o_data.last != beat_q[0].last)
                        report_mismatch("last", 64'(o_data.last), 64'(beat_q[0].last));
                    void'(beat_q.pop_front());
                end
            end
            if (hold_rx) begin
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    rx_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 30);
            end
        end
    end

    function automatic t_in mk(t_action a, logic [47:0] now, logic [31:0] ms,
                               logic rep, logic [4:0] id);
        t_in c;
        c.action = a;
        c.now_us = now;
        c.interval_ms = ms;
        c.repeat_req = rep;
        c.timer_id = id;
        return c;
    endfunction

    // sampled away from the driving edge so queue and valid are settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_q.size() != 0 || i_valid || beat_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int n;
        t_in c;
        for (int i = 0; i < MAX_TIMERS; i++) id_used[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        cmd_q.push_back(mk(ACT_TICK, 48'd0, 32'd0, 1'b0, 5'd0));
        cmd_q.push_back(mk(ACT_DEL, 48'd0, 32'd0, 1'b0, 5'd31));
        cmd_q.push_back(mk(ACT_ADD, 48'd0, 32'd0, 1'b1, 5'd0));
        cmd_q.push_back(mk(ACT_ADD, '1, '1, 1'b0, 5'd31));
        cmd_q.push_back(mk(ACT_ADD, 48'd100, 32'd5, 1'b0, 5'd0));
        cmd_q.push_back(mk(ACT_ADD, 48'd100, 32'd5, 1'b1, 5'd0));
        cmd_q.push_back(mk(ACT_DEL, 48'd0, 32'd0, 1'b0, 5'd2));
        cmd_q.push_back(mk(ACT_DEL, 48'd0, 32'd0, 1'b0, 5'd2));
        cmd_q.push_back(mk(ACT_TICK, 48'd0, 32'd0, 1'b0, 5'd0));
        cmd_q[$].action = 2'd3;
        cmd_q.push_back(mk(ACT_TICK, 48'd5100, 32'd0, 1'b0, 5'd0));
        cmd_q.push_back(mk(ACT_TICK, 48'd20000, 32'd0, 1'b0, 5'd0));
        for (int i = 0; i < 33; i++)
            cmd_q.push_back(mk(ACT_ADD, 48'd30000, 32'(i % 3), 1'(i), 5'd0));
        cmd_q.push_back(mk(ACT_TICK, 48'd40000, 32'd0, 1'b0, 5'd0));
        wait_drained();

        // long receiver hold-off with the sender still offering
        hold_rx = 1;
        for (int i = 0; i < 6; i++) cmd_q.push_back(mk(ACT_TICK, 48'(50000 + i * 2000),
                                                     32'd0, 1'b0, 5'd0));
        repeat (400) @(posedge i_clk);
        hold_rx = 0;
        wait_drained();
        for (int i = 0; i < 32; i++) cmd_q.push_back(mk(ACT_DEL, 48'd0, 32'd0, 1'b0, 5'(i)));
        wait_drained();

        // random
        clock_us = 48'd1000;
        n = 0;
        while (n < 70) begin
            n++;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = mk(ACT_ADD, clock_us,
                                   ($urandom_range(0, 19) == 0) ? 32'($urandom)
                                                                : 32'($urandom_range(0, 20)),
                                   1'($urandom), 5'd0);
                4, 5: c = mk(ACT_DEL, clock_us, $urandom, 1'($urandom), 5'($urandom));
                6, 7, 8: begin
                    clock_us = clock_us + 48'($urandom_range(0, 12000));
                    c = mk(ACT_TICK, clock_us, $urandom, 1'($urandom), 5'($urandom));
                end
                default: c = mk(ACT_ADD, 48'({$urandom, $urandom} >> 16), $urandom,
                                1'($urandom), 5'($urandom));
            endcase
            cmd_q.push_back(c);
            if (n == 35) wait_drained();
        end
        cmd_q.push_back(mk(ACT_TICK, '1, '1, 1'b1, '1));
        wait_drained();
        repeat (60) @(posedge i_clk);
        stim_done = 1;
    end

    initial begin
        while (!stim_done && cycles < LIMIT) @(posedge i_clk);
        if (!stim_done) begin
            $display("Testbench completed WITH ERRORS");
        end else if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mhts_pkg.sv
rtl/core/mhts_ram.sv
rtl/core/mhts_core.sv
rtl/core/min_heap_timer_scheduler_top.sv
rtl/core/mhts_checker.sv
test/min_heap_timer_scheduler_top_tb.sv
